>>> rtl/json_string_unescape_macros.svh
// Assertion helpers shared by the unescaper modules.
// Each expects clk and rst_n in scope at the point of use.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent at an edge implies consequent at the same edge.
`define JSU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_string_unescape: implication check failed");

// Expression must never be true at a clock edge.
`define JSU_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("json_string_unescape: forbidden condition seen");

`else

`define JSU_ASSERT_IMPL(label, ante, cons)
`define JSU_ASSERT_NEVER(label, expr)

`endif

`endif

>>> rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Input beat and result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } out_item_t;

    // Result status codes
    localparam logic [2:0] ST_BYTE       = 3'd0;
    localparam logic [2:0] ST_CLOSED     = 3'd1;
    localparam logic [2:0] ST_EXP_QUOTE  = 3'd2;
    localparam logic [2:0] ST_UNTERM_STR = 3'd3;
    localparam logic [2:0] ST_UNTERM_ESC = 3'd4;
    localparam logic [2:0] ST_UNKNOWN    = 3'd5;
    localparam logic [2:0] ST_BAD_HEX    = 3'd6;
    localparam logic [2:0] ST_TRUNC      = 3'd7;

    // Parser phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_BODY     = 4'd1;
    localparam logic [3:0] PH_ESC      = 4'd2;
    localparam logic [3:0] PH_HEX      = 4'd3;
    localparam logic [3:0] PH_HELD     = 4'd4;
    localparam logic [3:0] PH_HELD_ESC = 4'd5;
    localparam logic [3:0] PH_HELD_HEX = 4'd6;

    // Kind of the main part of a job
    localparam logic [1:0] MK_NONE = 2'd0;
    localparam logic [1:0] MK_BYTE = 2'd1;
    localparam logic [1:0] MK_CP   = 2'd2;

    // Segments of a job, in emission order
    localparam logic [1:0] SEG_PRE  = 2'd0;
    localparam logic [1:0] SEG_MAIN = 2'd1;
    localparam logic [1:0] SEG_TAIL = 2'd2;

    // Surrogate bounds
    localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Work handed from the front to the back: optional flush of a held high
    // surrogate, then an optional byte or code point, then an optional status
    // (ST_BYTE in tail means no status beat).
    typedef struct packed {
        logic        pre_en;
        logic [15:0] pre_cp;
        logic [1:0]  main_kind;
        logic [20:0] main_cp;
        logic [2:0]  tail;
    } job_t;

    // Queue head as seen by the back
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    // Hex digit: {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    // Number of UTF-8 bytes for a code point, 1 to 4
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80) begin
            n = 3'd1;
        end else if (cp < 21'h800) begin
            n = 3'd2;
        end else if (cp < SUPP_BASE) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // One byte of the UTF-8 form of a code point
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        case (len)
            3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            3'd4:
            begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: r = cp[7:0];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_macros.svh"

module jsu_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire jsu_pkg::in_item_t item,
    input  wire logic           full,
    output logic                item_stall,
    output logic                push,
    output jsu_pkg::job_t       job
);
    import jsu_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [1:0]  count_reg, count_next;
    logic [15:0] held_high_reg, held_next;

    logic        accept;
    logic [4:0]  hex;
    logic [15:0] accum_shift;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic        held_mode;
    logic [7:0]  b;

    assign item_stall = full;
    assign accept     = item_valid && !full;
    assign b          = item.data_byte;
    assign hex        = hex_digit(b);
    assign accum_shift = {accum_reg[11:0], hex[3:0]};

    // Decode the simple escapes
    always_comb
    begin
        esc_ok  = 1'b1;
        esc_val = b;
        case (b)
            CH_QUOTE:  esc_val = CH_QUOTE;
            CH_BSLASH: esc_val = CH_BSLASH;
            CH_SLASH:  esc_val = CH_SLASH;
            CH_B:      esc_val = 8'h08;
            CH_F:      esc_val = 8'h0C;
            CH_N:      esc_val = 8'h0A;
            CH_R:      esc_val = 8'h0D;
            CH_T:      esc_val = 8'h09;
            default:   esc_ok  = 1'b0;
        endcase
    end

    // Classify the beat and build the job for the back
    always_comb
    begin
        job        = '0;
        job.pre_cp = held_high_reg;
        phase_next = phase_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        held_next  = held_high_reg;
        held_mode  = (phase_reg == PH_HELD) || (phase_reg == PH_HELD_ESC) ||
                     (phase_reg == PH_HELD_HEX);

        if (item.text_end) begin
            // End of text: flush any held value, report and drop to idle
            phase_next = PH_IDLE;
            accum_next = '0;
            count_next = '0;
            held_next  = '0;
            job.pre_en = held_mode;
            unique case (phase_reg) inside
                PH_BODY, PH_HELD:         job.tail = ST_UNTERM_STR;
                PH_ESC, PH_HELD_ESC:      job.tail = ST_UNTERM_ESC;
                PH_HEX, PH_HELD_HEX:      job.tail = ST_TRUNC;
                default:                  job.tail = ST_EXP_QUOTE;
            endcase
        end else begin
            unique case (phase_reg) inside
                PH_BODY, PH_HELD:
                begin
                    if (phase_reg == PH_HELD && b == CH_BSLASH) begin
                        phase_next = PH_HELD_ESC;
                    end else begin
                        job.pre_en = held_mode;
                        held_next  = '0;
                        if (b == CH_QUOTE) begin
                            job.tail   = ST_CLOSED;
                            phase_next = PH_IDLE;
                            accum_next = '0;
                            count_next = '0;
                        end else if (b == CH_BSLASH) begin
                            phase_next = PH_ESC;
                        end else begin
                            job.main_kind = MK_BYTE;
                            job.main_cp   = {13'd0, b};
                            phase_next    = PH_BODY;
                        end
                    end
                end
                PH_ESC, PH_HELD_ESC:
                begin
                    if (b == CH_U) begin
                        phase_next = held_mode ? PH_HELD_HEX : PH_HEX;
                        accum_next = '0;
                        count_next = '0;
                    end else begin
                        job.pre_en = held_mode;
                        held_next  = '0;
                        if (esc_ok) begin
                            job.main_kind = MK_BYTE;
                            job.main_cp   = {13'd0, esc_val};
                            phase_next    = PH_BODY;
                        end else begin
                            job.tail   = ST_UNKNOWN;
                            phase_next = PH_IDLE;
                            accum_next = '0;
                            count_next = '0;
                        end
                    end
                end
                PH_HEX, PH_HELD_HEX:
                begin
                    if (!hex[4]) begin
                        // Bad digit: flush held value, report
                        job.pre_en = held_mode;
                        job.tail   = ST_BAD_HEX;
                        phase_next = PH_IDLE;
                        accum_next = '0;
                        count_next = '0;
                        held_next  = '0;
                    end else if (count_reg != 2'd3) begin
                        accum_next = accum_shift;
                        count_next = count_reg + 2'd1;
                    end else begin
                        accum_next = '0;
                        count_next = '0;
                        if (held_mode && accum_shift >= LOW_SUR_LO &&
                            accum_shift <= LOW_SUR_HI) begin
                            // Join the pair into one supplementary code point
                            job.main_kind = MK_CP;
                            job.main_cp   = SUPP_BASE +
                                            {1'b0, held_high_reg[9:0], accum_shift[9:0]};
                            held_next     = '0;
                            phase_next    = PH_BODY;
                        end else begin
                            job.pre_en = held_mode;
                            held_next  = '0;
                            if (accum_shift >= HIGH_SUR_LO && accum_shift <= HIGH_SUR_HI) begin
                                held_next  = accum_shift;
                                phase_next = PH_HELD;
                            end else begin
                                job.main_kind = MK_CP;
                                job.main_cp   = {5'd0, accum_shift};
                                phase_next    = PH_BODY;
                            end
                        end
                    end
                end
                default:
                begin
                    accum_next = '0;
                    count_next = '0;
                    held_next  = '0;
                    if (b == CH_QUOTE) begin
                        phase_next = PH_BODY;
                    end else begin
                        job.tail   = ST_EXP_QUOTE;
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    assign push = accept && (job.pre_en || job.main_kind != MK_NONE || job.tail != ST_BYTE);

    // Advance the parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            accum_reg     <= '0;
            count_reg     <= '0;
            held_high_reg <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            count_reg     <= count_next;
            held_high_reg <= held_next;
        end
    end

    `JSU_ASSERT_IMPL(a_held_only_in_held_phase, held_high_reg != 16'd0, held_mode)
    `JSU_ASSERT_IMPL(a_held_is_high_sur, held_mode,
                     held_high_reg >= HIGH_SUR_LO && held_high_reg <= HIGH_SUR_HI)

endmodule

`default_nettype wire

>>> rtl/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_macros.svh"

module jsu_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::job_t job,
    input  wire logic          pop,
    output logic               full,
    output jsu_pkg::head_t     head
);
    import jsu_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.job   = slot_reg[rd_ptr_reg];

    // Hold job payloads
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `JSU_ASSERT_NEVER(a_no_overflow, push && full && !pop)
    `JSU_ASSERT_NEVER(a_no_underflow, pop && !head.valid)

endmodule

`default_nettype wire

>>> rtl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_macros.svh"

module jsu_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire jsu_pkg::head_t   head,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output jsu_pkg::out_item_t    result
);
    import jsu_pkg::*;

    logic       started_reg, started_next;
    logic [1:0] seg_reg, seg_next;
    logic [1:0] idx_reg, idx_next;
    logic       result_valid_reg;
    out_item_t  result_reg;

    logic       has_main, has_tail;
    logic [2:0] main_len, seg_len;
    logic [1:0] start_seg, cur_seg, cur_idx, after_seg;
    logic       end_of_seg, more, last_beat;
    logic       load, issue;
    out_item_t  beat;

    assign has_main  = (head.job.main_kind != MK_NONE);
    assign has_tail  = (head.job.tail != ST_BYTE);
    assign main_len  = (head.job.main_kind == MK_CP) ? utf8_len(head.job.main_cp) : 3'd1;
    assign start_seg = head.job.pre_en ? SEG_PRE : (has_main ? SEG_MAIN : SEG_TAIL);
    assign cur_seg   = started_reg ? seg_reg : start_seg;
    assign cur_idx   = started_reg ? idx_reg : 2'd0;

    // Pick the current beat of the job
    always_comb
    begin
        beat      = '0;
        seg_len   = 3'd1;
        more      = 1'b0;
        after_seg = SEG_TAIL;
        unique case (cur_seg)
            SEG_PRE:
            begin
                seg_len        = 3'd3;
                beat.out_byte  = utf8_byte({5'd0, head.job.pre_cp}, 3'd3, cur_idx);
                more           = has_main || has_tail;
                after_seg      = has_main ? SEG_MAIN : SEG_TAIL;
            end
            SEG_MAIN:
            begin
                seg_len        = main_len;
                beat.out_byte  = (head.job.main_kind == MK_CP) ?
                                 utf8_byte(head.job.main_cp, main_len, cur_idx) :
                                 head.job.main_cp[7:0];
                more           = has_tail;
            end
            default:
            begin
                beat.status = head.job.tail;
            end
        endcase
        end_of_seg = ({1'b0, cur_idx} == seg_len - 3'd1);
        last_beat  = end_of_seg && !more;
        beat.last  = last_beat;
    end

    assign load  = !result_valid_reg || !result_stall;
    assign issue = head.valid && load;
    assign pop   = issue && last_beat;

    // Step through segments and beats
    always_comb
    begin
        started_next = started_reg;
        seg_next     = seg_reg;
        idx_next     = idx_reg;
        if (issue) begin
            if (last_beat) begin
                started_next = 1'b0;
                seg_next     = SEG_PRE;
                idx_next     = '0;
            end else if (end_of_seg) begin
                started_next = 1'b1;
                seg_next     = after_seg;
                idx_next     = '0;
            end else begin
                started_next = 1'b1;
                seg_next     = cur_seg;
                idx_next     = cur_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            started_reg      <= 1'b0;
            seg_reg          <= SEG_PRE;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            started_reg <= started_next;
            seg_reg     <= seg_next;
            idx_reg     <= idx_next;
            if (load) begin
                result_valid_reg <= head.valid;
            end
        end
    end

    // Hold the output beat while stalled
    always_ff @(posedge clk)
    begin
        if (issue) begin
            result_reg <= beat;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `JSU_ASSERT_IMPL(a_status_beat_is_last, result_valid_reg && result_reg.status != ST_BYTE,
                     result_reg.last && result_reg.out_byte == 8'd0)
    `JSU_ASSERT_IMPL(a_started_needs_job, started_reg, head.valid)

endmodule

`default_nettype wire

>>> rtl/json_string_unescape.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                   Beat
// item      item_valid / item_stall     data_byte, text_end
// result    result_valid / result_stall out_byte, status, last
//
// One input beat per cycle is taken whenever the two-entry job queue has room.
// An item yielding n results (n up to 6) has them issued by the back end one output beat
// per cycle while result_stall is low; items yielding none are never queued.
// The first result of a beat passes through a queue slot, then the output register.
// Reset clears parser state, queue pointers and output valid at once.
// The output register holds its beat while result_stall is high.

module json_string_unescape (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire jsu_pkg::in_item_t    item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output jsu_pkg::out_item_t        result
);
    import jsu_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    job_t  job;
    head_t head;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .full       (full),
        .item_stall (item_stall),
        .push       (push),
        .job        (job)
    );

    jsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .job   (job),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> dv/tb_json_string_unescape.sv
`timescale 1ns / 1ps

module tb_json_string_unescape;
    import jsu_pkg::*;

    localparam int ITEM_TARGET  = 470;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 50;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    json_string_unescape dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Beats waiting to be sent, and decoded beats still owed by the block
    in_item_t  pending_q[$];
    out_item_t decoded_q[$];

    // Shadow parser state
    logic [3:0]  ps_phase  = PH_IDLE;
    logic [15:0] ps_accum  = '0;
    logic [1:0]  ps_digits = '0;
    logic [15:0] ps_high   = '0;

    int   mismatches = 0;
    int   cycle_cnt  = 0;
    int   beat_no    = 0;
    int   send_gap   = 0;
    int   stall_left = 0;
    logic item_taken = 1'b0;

    logic [7:0] esc_chars [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("ERROR %0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Shadow unescaper
    // ------------------------------------------------------------------

    function automatic void add_result(input logic [7:0] b, input logic [2:0] st);
        out_item_t r;
        r.out_byte = (st == ST_BYTE) ? b : 8'h00;
        r.status   = st;
        r.last     = 1'b0;
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    function automatic void clear_parser();
        ps_phase  = PH_IDLE;
        ps_accum  = '0;
        ps_digits = '0;
        ps_high   = '0;
    endfunction

    function automatic void abort_with(input logic [2:0] st);
        add_result(8'h00, st);
        clear_parser();
    endfunction

    // Split a code point into its UTF-8 bytes
    function automatic void add_utf8(input int cp);
        if (cp < 'h80)
        begin
            add_result(8'(cp), ST_BYTE);
        end
        else if (cp < 'h800)
        begin
            add_result(8'('hC0 + (cp >> 6)), ST_BYTE);
            add_result(8'('h80 + (cp % 64)), ST_BYTE);
        end
        else if (cp < int'(SUPP_BASE))
        begin
            add_result(8'('hE0 + (cp >> 12)), ST_BYTE);
            add_result(8'('h80 + ((cp >> 6) % 64)), ST_BYTE);
            add_result(8'('h80 + (cp % 64)), ST_BYTE);
        end
        else
        begin
            add_result(8'('hF0 + (cp >> 18)), ST_BYTE);
            add_result(8'('h80 + ((cp >> 12) % 64)), ST_BYTE);
            add_result(8'('h80 + ((cp >> 6) % 64)), ST_BYTE);
            add_result(8'('h80 + (cp % 64)), ST_BYTE);
        end
    endfunction

    function automatic void release_high();
        add_utf8(int'(ps_high));
        ps_high = '0;
    endfunction

    function automatic void string_char(input logic [7:0] b);
        if (b == CH_QUOTE)
        begin
            abort_with(ST_CLOSED);
        end
        else if (b == CH_BSLASH)
        begin
            ps_phase = PH_ESC;
        end
        else
        begin
            add_result(b, ST_BYTE);
            ps_phase = PH_BODY;
        end
    endfunction

    function automatic void escape_char(input logic [7:0] b);
        logic [7:0] v;
        bit         simple;
        v      = b;
        simple = 1'b1;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: v = b;
            CH_B: v = 8'h08;
            CH_F: v = 8'h0C;
            CH_N: v = 8'h0A;
            CH_R: v = 8'h0D;
            CH_T: v = 8'h09;
            CH_U:
            begin
                ps_phase  = PH_HEX;
                ps_accum  = '0;
                ps_digits = '0;
                simple    = 1'b0;
            end
            default:
            begin
                abort_with(ST_UNKNOWN);
                simple = 1'b0;
            end
        endcase
        if (simple)
        begin
            add_result(v, ST_BYTE);
            ps_phase = PH_BODY;
        end
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - 'h30;
        if (b >= "a" && b <= "f") return int'(b) - 'h57;
        if (b >= "A" && b <= "F") return int'(b) - 'h37;
        return -1;
    endfunction

    // Hold a high surrogate, emit anything else
    function automatic void finish_unit(input logic [15:0] v);
        if (v >= HIGH_SUR_LO && v <= HIGH_SUR_HI)
        begin
            ps_high  = v;
            ps_phase = PH_HELD;
        end
        else
        begin
            add_utf8(int'(v));
            ps_phase = PH_BODY;
        end
    endfunction

    function automatic void hex_char(input logic [7:0] b, input bit held);
        int          d;
        logic [15:0] v;
        d = hex_nibble(b);
        if (d < 0)
        begin
            if (held) release_high();
            abort_with(ST_BAD_HEX);
            return;
        end
        ps_accum = {ps_accum[11:0], 4'(d)};
        if (ps_digits != 2'd3)
        begin
            ps_digits = ps_digits + 2'd1;
            return;
        end
        v         = ps_accum;
        ps_accum  = '0;
        ps_digits = '0;
        if (!held)
        begin
            finish_unit(v);
        end
        else if (v >= LOW_SUR_LO && v <= LOW_SUR_HI)
        begin
            // join the pair into one supplementary code point
            add_utf8(int'(SUPP_BASE) + ((int'(ps_high) - int'(HIGH_SUR_LO)) << 10)
                     + (int'(v) - int'(LOW_SUR_LO)));
            ps_high  = '0;
            ps_phase = PH_BODY;
        end
        else
        begin
            release_high();
            finish_unit(v);
        end
    endfunction

    // Work out every result that one input beat causes
    function automatic void decode_beat(input in_item_t beat);
        int         first;
        logic [7:0] b;
        first = decoded_q.size();
        b     = beat.data_byte;
        if (beat.text_end)
        begin
            case (ps_phase)
                PH_BODY:     abort_with(ST_UNTERM_STR);
                PH_ESC:      abort_with(ST_UNTERM_ESC);
                PH_HEX:      abort_with(ST_TRUNC);
                PH_HELD:
                begin
                    release_high();
                    abort_with(ST_UNTERM_STR);
                end
                PH_HELD_ESC:
                begin
                    release_high();
                    abort_with(ST_UNTERM_ESC);
                end
                PH_HELD_HEX:
                begin
                    release_high();
                    abort_with(ST_TRUNC);
                end
                default:     abort_with(ST_EXP_QUOTE);
            endcase
        end
        else
        begin
            case (ps_phase)
                PH_BODY: string_char(b);
                PH_ESC:  escape_char(b);
                PH_HEX:  hex_char(b, 1'b0);
                PH_HELD:
                begin
                    if (b == CH_BSLASH)
                    begin
                        ps_phase = PH_HELD_ESC;
                    end
                    else
                    begin
                        release_high();
                        string_char(b);
                    end
                end
                PH_HELD_ESC:
                begin
                    if (b == CH_U)
                    begin
                        ps_phase  = PH_HELD_HEX;
                        ps_accum  = '0;
                        ps_digits = '0;
                    end
                    else
                    begin
                        release_high();
                        escape_char(b);
                    end
                end
                PH_HELD_HEX: hex_char(b, 1'b1);
                default:
                begin
                    if (b == CH_QUOTE)
                    begin
                        clear_parser();
                        ps_phase = PH_BODY;
                    end
                    else
                    begin
                        abort_with(ST_EXP_QUOTE);
                    end
                end
            endcase
        end
        // mark the final result of this beat
        if (decoded_q.size() > first)
        begin
            decoded_q[decoded_q.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic void send_byte(input logic [7:0] b);
        in_item_t t;
        t.data_byte = b;
        t.text_end  = 1'b0;
        pending_q.insert(pending_q.size(), t);
    endfunction

    function automatic void send_end();
        in_item_t t;
        t.data_byte = 8'($urandom_range(0, 255));
        t.text_end  = 1'b1;
        pending_q.insert(pending_q.size(), t);
    endfunction

    // Hex letters come in either case
    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        if ($urandom_range(0, 1) == 1) return 8'h37 + {4'h0, n};
        return 8'h57 + {4'h0, n};
    endfunction

    function automatic void send_unit(input logic [15:0] v);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(hex_ascii(v[15 - 4 * i -: 4]));
        end
    endfunction

    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 6))
            0:       return 16'($urandom_range(0, 'h7F));
            1:       return 16'($urandom_range('h80, 'h7FF));
            2:       return 16'($urandom_range('h800, 'hD7FF));
            3:       return 16'($urandom_range('hE000, 'hFFFF));
            4:       return ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'h0000;
            5:       return 16'($urandom_range('hD800, 'hDBFF));
            default: return 16'($urandom_range('hDC00, 'hDFFF));
        endcase
    endfunction

    // One piece of string content; broke is set when it ends the string
    function automatic void send_token(output bit broke);
        logic [7:0] b;
        int         k;
        broke = 1'b0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
            begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH);
                send_byte(b);
            end
            6, 7, 8:
            begin
                send_byte(CH_BSLASH);
                send_byte(esc_chars[$urandom_range(0, 7)]);
            end
            9, 10, 11:
                send_unit(pick_unit());
            12, 13:
            begin
                send_unit(16'($urandom_range('hD800, 'hDBFF)));
                send_unit(16'($urandom_range('hDC00, 'hDFFF)));
            end
            14:
                // lone high surrogate: whatever follows decides its fate
                send_unit(16'($urandom_range('hD800, 'hDBFF)));
            15:
            begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_U || b inside {esc_chars});
                send_byte(CH_BSLASH);
                send_byte(b);
                broke = 1'b1;
            end
            16:
            begin
                send_byte(CH_BSLASH);
                send_byte(CH_U);
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                begin
                    send_byte(hex_ascii(4'($urandom_range(0, 15))));
                end
                do b = 8'($urandom_range(0, 255));
                while (hex_nibble(b) >= 0);
                send_byte(b);
                broke = 1'b1;
            end
            17:
            begin
                // cut the text short inside an escape
                send_byte(CH_BSLASH);
                k = $urandom_range(0, 4);
                if (k > 0) send_byte(CH_U);
                for (int i = 1; i < k; i++)
                begin
                    send_byte(hex_ascii(4'($urandom_range(0, 15))));
                end
                send_end();
                broke = 1'b1;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       send_byte(8'h00);
                    1:       send_byte(8'hFF);
                    2:       send_byte(8'h7F);
                    default: send_byte(8'h80);
                endcase
            end
        endcase
    endfunction

    function automatic void send_string();
        int n;
        bit broke;
        broke = 1'b0;
        send_byte(CH_QUOTE);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n && !broke; i++)
        begin
            send_token(broke);
        end
        if (!broke)
        begin
            if ($urandom_range(0, 9) < 2) send_end();
            else send_byte(CH_QUOTE);
        end
    endfunction

    // Junk between strings, parser idle
    function automatic void send_noise();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 0)
        begin
            send_end();
        end
        else
        begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE);
            send_byte(b);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // advance to the next beat once the current one is taken
            if (!item_valid || item_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    item       <= pending_q.pop_front();
                    item_valid <= 1'b1;
                    send_gap   = ((cycle_cnt / 256) % 4 == 3) ? 0 : pick_gap();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end

            // stall the result channel in runs
            if (stall_left == 0)
            begin
                stall_left = ((cycle_cnt / 256) % 4 == 1) ? 0 : pick_gap();
            end
            result_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input beats, check accepted results
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_item_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n)
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && item_stall === 1'b0)
            begin
                decode_beat(item);
            end
            if (result_valid === 1'b1 && result_stall == 1'b0)
            begin
                beat_no++;
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %0d not expected (byte %h status %0d)",
                                              beat_no, result.out_byte, result.status));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch($sformatf("result beat %0d out_byte %h, want %h",
                                                  beat_no, result.out_byte, want.out_byte));
                    if (result.status !== want.status)
                        report_mismatch($sformatf("result beat %0d status %0d, want %0d",
                                                  beat_no, result.status, want.status));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("result beat %0d last %b, want %b",
                                                  beat_no, result.last, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, drain, conclude
    // ------------------------------------------------------------------

    initial
    begin
        // directed opening: idle errors, byte extremes, escaped backslash,
        // surrogate pair, unknown escape, empty string
        send_byte(8'h78);
        send_end();
        send_byte(CH_QUOTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_byte(CH_BSLASH);
        send_unit(16'hD83D);
        send_unit(16'hDE00);
        send_byte(CH_BSLASH);
        send_byte(8'h71);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);

        // random strings, mostly well formed, with some junk between them
        while (pending_q.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_string();
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every beat to be sent and every result to arrive
        while (pending_q.size() != 0 || item_valid || decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
